[src/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, widths and the cordic angle table for the quaternion to
// euler bins core
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QW           = 16;   // quaternion component
    localparam int SUMW         = 34;   // q28 product sums
    localparam int SW           = 30;   // clamped pitch sine, q28
    localparam int NW           = 57;   // sqrt radicand
    localparam int RW           = 59;   // sqrt root and trial value
    localparam int CW           = 29;   // sqrt result
    localparam int VW           = 38;   // cordic vector
    localparam int AW           = 18;   // angle, signed turns with 16 fraction bits
    localparam int BW           = 5;    // output bin
    localparam int SQ_STEPS     = 29;
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;
    localparam int HALF_TURN    = 32768;
    localparam int QUARTER_TURN = 16384;

    typedef struct packed {
        logic [QW-1:0] quat_w;
        logic [QW-1:0] quat_x;
        logic [QW-1:0] quat_y;
        logic [QW-1:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic [SUMW-1:0] roll_y;
        logic [SUMW-1:0] roll_x;
        logic [SUMW-1:0] yaw_y;
        logic [SUMW-1:0] yaw_x;
        logic [SW-1:0]   s;
    } t_raw;

    typedef struct packed {
        logic [NW-1:0] n;
        logic [RW-1:0] r;
    } t_sq;

    typedef struct packed {
        logic [VW-1:0] x;
        logic [VW-1:0] y;
        logic [AW-1:0] ang;
        logic          zero;
    } t_vec;

    // atan(2^-i) in turns, 65536 per turn
    function automatic logic [13:0] atan_lut(input int unsigned idx);
        logic [13:0] v;
        case (idx)
            0:       v = 14'd8192;
            1:       v = 14'd4836;
            2:       v = 14'd2555;
            3:       v = 14'd1297;
            4:       v = 14'd651;
            5:       v = 14'd326;
            6:       v = 14'd163;
            7:       v = 14'd81;
            8:       v = 14'd41;
            9:       v = 14'd20;
            10:      v = 14'd10;
            11:      v = 14'd5;
            12:      v = 14'd3;
            13:      v = 14'd1;
            14:      v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

endpackage

[src/qte_in_if.sv]
// ----------------------------------------------------------------------------
// qte_in_if
// quaternion input channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface qte_in_if;
    logic                   valid;
    logic                   ready;
    logic [qte_pkg::QW-1:0] quat_w;
    logic [qte_pkg::QW-1:0] quat_x;
    logic [qte_pkg::QW-1:0] quat_y;
    logic [qte_pkg::QW-1:0] quat_z;

    modport source(output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
    modport sink(input valid, input quat_w, input quat_x, input quat_y,
                 input quat_z, output ready);
endinterface

[src/qte_out_if.sv]
// ----------------------------------------------------------------------------
// qte_out_if
// euler bin output channel, valid/ready with payload
// ----------------------------------------------------------------------------
interface qte_out_if;
    logic                   valid;
    logic                   ready;
    logic [qte_pkg::BW-1:0] roll_bin;
    logic [qte_pkg::BW-1:0] pitch_bin;
    logic [qte_pkg::BW-1:0] yaw_bin;

    modport source(output valid, output roll_bin, output pitch_bin,
                   output yaw_bin, input ready);
    modport sink(input valid, input roll_bin, input pitch_bin,
                 input yaw_bin, output ready);
endinterface

[src/qte_fifo.sv]
// ----------------------------------------------------------------------------
// qte_fifo
// front queue, takes input beats while the back pipeline is stalled, until it is full
// ----------------------------------------------------------------------------
module qte_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qte_in_if.sink         i_in,
    input  logic           i_pop,
    output logic           o_valid,
    output qte_pkg::t_quat o_head
);

    qte_pkg::t_quat              r_mem [qte_pkg::QDEPTH];
    logic [qte_pkg::QAW-1:0]     r_wr, n_wr;
    logic [qte_pkg::QAW-1:0]     r_rd, n_rd;
    logic [qte_pkg::QAW:0]       r_cnt, n_cnt;
    logic                        push;
    logic                        pop;

    assign i_in.ready = (r_cnt != (qte_pkg::QAW+1)'(qte_pkg::QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = (r_cnt != '0);
    assign pop        = i_pop && o_valid;
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (qte_pkg::QAW+1)'(push) - (qte_pkg::QAW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{quat_w: i_in.quat_w, quat_x: i_in.quat_x,
                             quat_y: i_in.quat_y, quat_z: i_in.quat_z};
        end
    end

endmodule

[src/qte_cordic_stage.sv]
// ----------------------------------------------------------------------------
// qte_cordic_stage
// one registered vectoring micro-rotation
// ----------------------------------------------------------------------------
module qte_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_vec i_vec,
    output qte_pkg::t_vec o_vec
);

    logic signed [qte_pkg::VW-1:0] x, y, dx, dy;
    logic signed [qte_pkg::AW-1:0] ang, da;
    qte_pkg::t_vec                 r_vec, n_vec;

    assign x   = $signed(i_vec.x);
    assign y   = $signed(i_vec.y);
    assign dx  = y >>> STEP;
    assign dy  = x >>> STEP;
    assign ang = $signed(i_vec.ang);
    assign da  = qte_pkg::AW'(qte_pkg::atan_lut(STEP));

    always_comb begin
        n_vec.zero = i_vec.zero;
        if (!y[qte_pkg::VW-1]) begin
            n_vec.x   = x + dx;
            n_vec.y   = y - dy;
            n_vec.ang = ang + da;
        end else begin
            n_vec.x   = x - dx;
            n_vec.y   = y + dy;
            n_vec.ang = ang - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

[src/qte_pipe.sv]
// ----------------------------------------------------------------------------
// qte_pipe
// back pipeline: products, sums, pitch cosine by sqrt, three cordics, bins
// ----------------------------------------------------------------------------
module qte_pipe #(
    parameter int BINS         = 18,
    parameter int CORDIC_STEPS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  qte_pkg::t_quat i_head,
    output logic           o_pop,
    qte_out_if.source      o_out
);

    localparam int LAT = 4 + qte_pkg::SQ_STEPS + 1 + CORDIC_STEPS;
    localparam logic signed [qte_pkg::SUMW-1:0] ONE_Q28 = qte_pkg::SUMW'(1) <<< 28;
    localparam logic [qte_pkg::NW-1:0] ONE_Q56 = qte_pkg::NW'(1) << 56;
    localparam logic signed [qte_pkg::AW-1:0] ANG_HALF = qte_pkg::AW'(qte_pkg::HALF_TURN);
    localparam logic signed [qte_pkg::AW-1:0] ANG_QTR  = qte_pkg::AW'(qte_pkg::QUARTER_TURN);

    logic           en;
    logic [LAT-1:0] r_valid;

    assign en    = !r_valid[LAT-1] || o_out.ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    // products
    logic signed [31:0] r_wx, r_yz, r_wz, r_xy, r_xx, r_yy, r_zz, r_wy, r_zx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= $signed(i_head.quat_w) * $signed(i_head.quat_x);
            r_yz <= $signed(i_head.quat_y) * $signed(i_head.quat_z);
            r_wz <= $signed(i_head.quat_w) * $signed(i_head.quat_z);
            r_xy <= $signed(i_head.quat_x) * $signed(i_head.quat_y);
            r_xx <= $signed(i_head.quat_x) * $signed(i_head.quat_x);
            r_yy <= $signed(i_head.quat_y) * $signed(i_head.quat_y);
            r_zz <= $signed(i_head.quat_z) * $signed(i_head.quat_z);
            r_wy <= $signed(i_head.quat_w) * $signed(i_head.quat_y);
            r_zx <= $signed(i_head.quat_z) * $signed(i_head.quat_x);
        end
    end

    // q28 sums and pitch clamp
    logic signed [qte_pkg::SUMW-1:0] sraw;
    logic signed [qte_pkg::SW-1:0]   sclamp;
    qte_pkg::t_raw                   r_b;

    assign sraw = (qte_pkg::SUMW'(r_wy) - qte_pkg::SUMW'(r_zx)) <<< 1;

    always_comb begin
        if (sraw > ONE_Q28) begin
            sclamp = qte_pkg::SW'(ONE_Q28);
        end else if (sraw < -ONE_Q28) begin
            sclamp = qte_pkg::SW'(-ONE_Q28);
        end else begin
            sclamp = qte_pkg::SW'(sraw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b.roll_y <= (qte_pkg::SUMW'(r_wx) + qte_pkg::SUMW'(r_yz)) <<< 1;
            r_b.roll_x <= ONE_Q28 - ((qte_pkg::SUMW'(r_xx) + qte_pkg::SUMW'(r_yy)) <<< 1);
            r_b.yaw_y  <= (qte_pkg::SUMW'(r_wz) + qte_pkg::SUMW'(r_xy)) <<< 1;
            r_b.yaw_x  <= ONE_Q28 - ((qte_pkg::SUMW'(r_yy) + qte_pkg::SUMW'(r_zz)) <<< 1);
            r_b.s      <= sclamp;
        end
    end

    // radicand 1 - s^2 in q56
    logic signed [2*qte_pkg::SW-1:0] ssq;
    qte_pkg::t_raw                   r_c_raw;
    qte_pkg::t_sq                    r_c_sq;

    assign ssq = $signed(r_b.s) * $signed(r_b.s);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_raw  <= r_b;
            r_c_sq.n <= ONE_Q56 - ssq[qte_pkg::NW-1:0];
            r_c_sq.r <= '0;
        end
    end

    // digit-by-digit square root, one root bit per stage
    qte_pkg::t_sq  sq_in   [qte_pkg::SQ_STEPS];
    qte_pkg::t_sq  sq_out  [qte_pkg::SQ_STEPS];
    qte_pkg::t_raw raw_in  [qte_pkg::SQ_STEPS];
    qte_pkg::t_raw raw_out [qte_pkg::SQ_STEPS];

    assign sq_in[0]  = r_c_sq;
    assign raw_in[0] = r_c_raw;

    for (genvar k = 0; k < qte_pkg::SQ_STEPS; k++) begin : g_sqrt
        localparam logic [qte_pkg::RW-1:0] BIT =
            qte_pkg::RW'(1) << (2 * (qte_pkg::SQ_STEPS - 1 - k));
        logic [qte_pkg::RW-1:0] trial;
        qte_pkg::t_sq           r_sq;
        qte_pkg::t_raw          r_raw;

        if (k > 0) begin : g_link
            assign sq_in[k]  = sq_out[k-1];
            assign raw_in[k] = raw_out[k-1];
        end

        assign trial = sq_in[k].r + BIT;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_raw <= raw_in[k];
                if (qte_pkg::RW'(sq_in[k].n) >= trial) begin
                    r_sq.n <= sq_in[k].n - qte_pkg::NW'(trial);
                    r_sq.r <= (sq_in[k].r >> 1) + BIT;
                end else begin
                    r_sq.n <= sq_in[k].n;
                    r_sq.r <= sq_in[k].r >> 1;
                end
            end
        end

        assign sq_out[k]  = r_sq;
        assign raw_out[k] = r_raw;
    end

    // half-plane fold and zero detect
    function automatic qte_pkg::t_vec pre_rot(input logic signed [qte_pkg::VW-1:0] y,
                                              input logic signed [qte_pkg::VW-1:0] x);
        qte_pkg::t_vec v;
        v.zero = (x == '0) && (y == '0);
        if (x[qte_pkg::VW-1]) begin
            v.x   = -x;
            v.y   = -y;
            v.ang = y[qte_pkg::VW-1] ? -ANG_HALF : ANG_HALF;
        end else begin
            v.x   = x;
            v.y   = y;
            v.ang = '0;
        end
        return v;
    endfunction

    qte_pkg::t_raw             fin_raw;
    logic [qte_pkg::CW-1:0]    cosv;
    qte_pkg::t_vec             r_pre [3];

    assign fin_raw = raw_out[qte_pkg::SQ_STEPS-1];
    assign cosv    = sq_out[qte_pkg::SQ_STEPS-1].r[qte_pkg::CW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre[0] <= pre_rot(qte_pkg::VW'($signed(fin_raw.roll_y)),
                                qte_pkg::VW'($signed(fin_raw.roll_x)));
            r_pre[1] <= pre_rot(qte_pkg::VW'($signed(fin_raw.s)), qte_pkg::VW'(cosv));
            r_pre[2] <= pre_rot(qte_pkg::VW'($signed(fin_raw.yaw_y)),
                                qte_pkg::VW'($signed(fin_raw.yaw_x)));
        end
    end

    // cordic chains: roll, pitch, yaw
    qte_pkg::t_vec cv [CORDIC_STEPS+1][3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        assign cv[0][ch] = r_pre[ch];
        for (genvar st = 0; st < CORDIC_STEPS; st++) begin : g_step
            qte_cordic_stage #(.STEP(st)) u_stage (
                .i_clk (i_clk),
                .i_en  (en),
                .i_vec (cv[st][ch]),
                .o_vec (cv[st+1][ch])
            );
        end
    end

    function automatic logic [qte_pkg::BW-1:0] full_bin(input qte_pkg::t_vec v);
        logic signed [qte_pkg::AW-1:0] a;
        logic [16:0]                   u;
        logic [24:0]                   p;
        a = v.zero ? '0 : $signed(v.ang);
        if (a > ANG_HALF) begin
            a = ANG_HALF;
        end else if (a < -ANG_HALF) begin
            a = -ANG_HALF;
        end
        u = 17'(a + ANG_HALF);
        p = 25'(u) * 25'(BINS);
        return p[20:16];
    endfunction

    function automatic logic [qte_pkg::BW-1:0] half_bin(input qte_pkg::t_vec v);
        logic signed [qte_pkg::AW-1:0] a;
        logic [15:0]                   u;
        logic [24:0]                   p;
        a = v.zero ? '0 : $signed(v.ang);
        if (a > ANG_QTR) begin
            a = ANG_QTR;
        end else if (a < -ANG_QTR) begin
            a = -ANG_QTR;
        end
        u = 16'(a + ANG_QTR);
        p = 25'(u) * 25'(BINS);
        return p[19:15];
    endfunction

    logic [qte_pkg::BW-1:0] r_roll, r_pitch, r_yaw;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= full_bin(cv[CORDIC_STEPS][0]);
            r_pitch <= half_bin(cv[CORDIC_STEPS][1]);
            r_yaw   <= full_bin(cv[CORDIC_STEPS][2]);
        end
    end

    assign o_out.valid     = r_valid[LAT-1];
    assign o_out.roll_bin  = r_roll;
    assign o_out.pitch_bin = r_pitch;
    assign o_out.yaw_bin   = r_yaw;

endmodule

[src/quaternion_to_euler_bins_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins_core
// unit quaternion in q1.14 to quantized roll, pitch and yaw bins
//
//   channel  dir  payload                          handshake
//   i_in     in   quat_w, quat_x, quat_y, quat_z   valid/ready
//   o_out    out  roll_bin, pitch_bin, yaw_bin     valid/ready
//
// one beat per cycle sustained while o_out is not held; results pass through the
// 29-stage square root and the cordic stages
// a four-entry input queue keeps taking beats while the output beat waits, until full;
// the back pipeline stalls as a whole while o_out is held
// synchronous active-low reset clears the queue and pipeline valid bits
// ----------------------------------------------------------------------------
module quaternion_to_euler_bins_core #(
    parameter int BINS         = 18,
    parameter int CORDIC_STEPS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qte_in_if.sink    i_in,
    qte_out_if.source o_out
);

    logic           head_valid;
    logic           pop;
    qte_pkg::t_quat head;

    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    qte_pipe #(
        .BINS         (BINS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
